// ----- hdl/dlce_pkg.sv -----
// Shared widths, operation and status codes, and memory write-enable type.
package dlce_pkg;

    localparam int MODE_W   = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [MODE_W-1:0] MODE_FIRST      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_NEXT       = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LAST       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PREV       = 4'd3;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd4;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_PUSH_AFTER = 4'd6;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_POP_CURSOR = 4'd9;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Field write enables for the node store
    typedef struct packed {
        logic val;
        logic succ;
        logic pred;
    } wr_en_t;

endpackage

// ----- hdl/dlce_cmd_if.sv -----
// Command channel: one list operation per item.
interface dlce_cmd_if import dlce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] item_value;

    modport source (output valid, output mode, output item_value, input ready);
    modport sink   (input valid, input mode, input item_value, output ready);
endinterface

// ----- hdl/dlce_rsp_if.sv -----
// Response channel: one result item per operation.
interface dlce_rsp_if import dlce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   result_value;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  element_count;

    modport source (output valid, output result_value, output found, output status,
                    output element_count, input ready);
    modport sink   (input valid, input result_value, input found, input status,
                    input element_count, output ready);
endinterface

// ----- hdl/dlce_node_store.sv -----
// Node pool storage: value memory and link memory with registered reads.
module dlce_node_store
    import dlce_pkg::*;
#(
    parameter int NODE_COUNT = 256,
    parameter int STORE_W    = 32,
    parameter int IDX_W      = 9
)
(
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(NODE_COUNT)-1:0] rd_a_addr,
    input  logic [$clog2(NODE_COUNT)-1:0] rd_b_addr,
    output logic [IDX_W-1:0]              rd_a_succ,
    output logic [IDX_W-1:0]              rd_b_succ,
    output logic [IDX_W-1:0]              rd_b_pred,
    output logic [STORE_W-1:0]            rd_b_val,
    input  wr_en_t                        wr_en,
    input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  logic [STORE_W-1:0]            wr_val,
    input  logic [IDX_W-1:0]              wr_succ,
    input  logic [IDX_W-1:0]              wr_pred
);

    typedef struct packed {
        logic [IDX_W-1:0] succ;
        logic [IDX_W-1:0] pred;
    } link_t;

    logic [STORE_W-1:0] val_mem  [NODE_COUNT];
    link_t              link_mem [NODE_COUNT];

    logic [IDX_W-1:0]   rd_a_succ_reg;
    logic [IDX_W-1:0]   rd_b_succ_reg;
    logic [IDX_W-1:0]   rd_b_pred_reg;
    logic [STORE_W-1:0] rd_b_val_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.val)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (wr_en.succ)
        begin
            link_mem[wr_addr].succ <= wr_succ;
        end
        if (wr_en.pred)
        begin
            link_mem[wr_addr].pred <= wr_pred;
        end
    end

    // Port A reads the free chain, port B the node being worked on
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_succ_reg <= link_mem[rd_a_addr].succ;
            rd_b_succ_reg <= link_mem[rd_b_addr].succ;
            rd_b_pred_reg <= link_mem[rd_b_addr].pred;
            rd_b_val_reg  <= val_mem[rd_b_addr];
        end
    end

    assign rd_a_succ = rd_a_succ_reg;
    assign rd_b_succ = rd_b_succ_reg;
    assign rd_b_pred = rd_b_pred_reg;
    assign rd_b_val  = rd_b_val_reg;

endmodule

// ----- hdl/doubly_linked_list_cursor_engine_top.sv -----
// Doubly linked list with cursor over a fixed node pool; top level sequencer.
//
// Usage:
//   cmd carries one operation per item (mode, item_value); rsp returns one
//   result item per operation (result_value, found, status, element_count).
//   Both channels move an item on a clock edge with valid and ready high.
// Sequencing:
//   Operations run one at a time. Each passes through an exec and a done
//   state; first/last, clear, undefined modes and anything refused or that
//   links no neighbour go straight from exec to done. A successful next/prev
//   adds a move state for the dependent read; pushes and pops that relink
//   neighbours add the write state S_WR2, and S_WR3 as well when a successor's
//   back link is rewritten too, all through the single memory write port.
//   The result item is registered as the sequencer leaves done for idle, so
//   the next item is taken while an earlier result still waits; if that result
//   is still not taken, the sequencer holds in its done state and cmd.ready stays low.
// Reset:
//   rst_n clears head, tail, cursor, free chain, pool mark and count; the
//   node memories are not cleared, every node is written before it is read.
module doubly_linked_list_cursor_engine_top
    import dlce_pkg::*;
#(
    parameter int NODE_COUNT  = 256,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    dlce_cmd_if.sink      cmd,
    dlce_rsp_if.source    rsp
);

    localparam int IDX_W   = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(NODE_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_WR3  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic [IDX_W-1:0]    free_reg, free_next;
    logic [IDX_W-1:0]    mark_reg, mark_next;
    logic [IDX_W-1:0]    fill_reg, fill_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [STORE_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]    anchor_reg, anchor_next;
    logic [STORE_W-1:0]  res_reg, res_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    wr_en_t              w2_we_reg, w2_we_next;
    logic [IDX_W-1:0]    w2_addr_reg, w2_addr_next;
    logic [IDX_W-1:0]    w2_data_reg, w2_data_next;
    logic                w3_on_reg, w3_on_next;
    logic [IDX_W-1:0]    w3_addr_reg, w3_addr_next;
    logic [IDX_W-1:0]    w3_data_reg, w3_data_next;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_value_reg;
    logic                out_found_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                cmd_fire;
    logic                slot_free;
    logic [IDX_W-1:0]    anchor_in;
    logic [IDX_W-1:0]    move_t;
    logic                anchor_ok;
    logic                take_free;
    logic                take_mark;
    logic [IDX_W-1:0]    new_n;
    logic [IDX_W-1:0]    head_new;
    logic [IDX_W-1:0]    tail_new;
    logic [IDX_W-1:0]    rd_b_idx;
    logic                rd_en;

    logic [IDX_W-1:0]    rd_a_succ;
    logic [IDX_W-1:0]    rd_b_succ;
    logic [IDX_W-1:0]    rd_b_pred;
    logic [STORE_W-1:0]  rd_b_val;
    wr_en_t              wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [STORE_W-1:0]  wr_val;
    logic [IDX_W-1:0]    wr_succ;
    logic [IDX_W-1:0]    wr_pred;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    // Node that the operation starts from
    always_comb
    begin
        unique case (cmd.mode)
            MODE_FIRST, MODE_POP_FRONT:                anchor_in = head_reg;
            MODE_LAST, MODE_POP_BACK, MODE_PUSH_BACK:  anchor_in = tail_reg;
            default:                                   anchor_in = cursor_reg;
        endcase
    end

    assign anchor_ok = (anchor_reg < NIL);
    assign move_t    = !anchor_ok ? NIL :
                       ((mode_reg == MODE_NEXT) ? rd_b_succ : rd_b_pred);
    assign take_free = (free_reg < NIL);
    assign take_mark = (mark_reg < NIL);
    assign new_n     = take_free ? free_reg : mark_reg;
    assign head_new  = (rd_b_pred < NIL) ? head_reg : rd_b_succ;
    assign tail_new  = (rd_b_succ < NIL) ? tail_reg : rd_b_pred;

    // Second read for next/prev fetches the target's value
    assign rd_b_idx = (state_reg == S_IDLE) ? anchor_in : move_t;
    assign rd_en    = cmd_fire || (state_reg == S_EXEC);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cursor_next  = cursor_reg;
        free_next    = free_reg;
        mark_next    = mark_reg;
        fill_next    = fill_reg;
        mode_next    = mode_reg;
        value_next   = value_reg;
        anchor_next  = anchor_reg;
        res_next     = res_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        w2_we_next   = w2_we_reg;
        w2_addr_next = w2_addr_reg;
        w2_data_next = w2_data_reg;
        w3_on_next   = w3_on_reg;
        w3_addr_next = w3_addr_reg;
        w3_data_next = w3_data_reg;
        wr_en        = '0;
        wr_idx       = new_n;
        wr_val       = value_reg;
        wr_succ      = NIL;
        wr_pred      = NIL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    mode_next   = cmd.mode;
                    value_next  = STORE_W'(cmd.item_value);
                    anchor_next = anchor_in;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next    = '0;
                found_next  = 1'b0;
                status_next = ST_OK;
                w2_we_next  = '0;
                w3_on_next  = 1'b0;
                state_next  = S_DONE;
                unique case (mode_reg)
                    MODE_FIRST, MODE_LAST:
                    begin
                        if (anchor_ok)
                        begin
                            cursor_next = anchor_reg;
                            res_next    = rd_b_val;
                            found_next  = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                    MODE_NEXT, MODE_PREV:
                    begin
                        if (move_t < NIL)
                        begin
                            cursor_next = move_t;
                            state_next  = S_MOVE;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                    MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_PUSH_AFTER:
                    begin
                        // push_back moves the cursor to the old tail even if refused
                        if (mode_reg == MODE_PUSH_BACK)
                        begin
                            cursor_next = anchor_reg;
                        end
                        if (mode_reg == MODE_PUSH_AFTER && !anchor_ok)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (!take_free && !take_mark)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            if (take_free)
                            begin
                                free_next = rd_a_succ;
                            end
                            else
                            begin
                                mark_next = mark_reg + IDX_W'(1);
                            end
                            fill_next = fill_reg + IDX_W'(1);
                            wr_idx    = new_n;
                            wr_en     = '{val: 1'b1, succ: 1'b1, pred: 1'b1};
                            head_next = head_reg;
                            if (mode_reg == MODE_PUSH_FRONT)
                            begin
                                wr_succ   = head_reg;
                                wr_pred   = NIL;
                                head_next = new_n;
                                if (head_reg < NIL)
                                begin
                                    w2_we_next   = '{val: 1'b0, succ: 1'b0, pred: 1'b1};
                                    w2_addr_next = head_reg;
                                    w2_data_next = new_n;
                                end
                                else
                                begin
                                    tail_next = new_n;
                                end
                            end
                            else if (anchor_ok)
                            begin
                                wr_succ      = rd_b_succ;
                                wr_pred      = anchor_reg;
                                w2_we_next   = '{val: 1'b0, succ: 1'b1, pred: 1'b0};
                                w2_addr_next = anchor_reg;
                                w2_data_next = new_n;
                                if (rd_b_succ < NIL)
                                begin
                                    w3_on_next   = 1'b1;
                                    w3_addr_next = rd_b_succ;
                                    w3_data_next = new_n;
                                end
                                else
                                begin
                                    tail_next = new_n;
                                end
                            end
                            else
                            begin
                                // empty list: new node is the only one
                                head_next = new_n;
                                tail_next = new_n;
                            end
                        end
                    end
                    MODE_POP_FRONT, MODE_POP_BACK, MODE_POP_CURSOR:
                    begin
                        cursor_next = anchor_reg;
                        if (!anchor_ok)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_next   = rd_b_val;
                            found_next = 1'b1;
                            // removed node heads the free chain
                            wr_idx     = anchor_reg;
                            wr_en      = '{val: 1'b0, succ: 1'b1, pred: 1'b0};
                            wr_succ    = free_reg;
                            free_next  = anchor_reg;
                            if (rd_b_pred < NIL)
                            begin
                                w2_we_next   = '{val: 1'b0, succ: 1'b1, pred: 1'b0};
                                w2_addr_next = rd_b_pred;
                                w2_data_next = rd_b_succ;
                            end
                            if (rd_b_succ < NIL)
                            begin
                                w3_on_next   = 1'b1;
                                w3_addr_next = rd_b_succ;
                                w3_data_next = rd_b_pred;
                            end
                            head_next   = head_new;
                            tail_next   = tail_new;
                            cursor_next = (head_new >= NIL && tail_new >= NIL) ? NIL
                                                                               : rd_b_succ;
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_reg - IDX_W'(1);
                            end
                        end
                    end
                    MODE_CLEAR:
                    begin
                        head_next   = NIL;
                        tail_next   = NIL;
                        cursor_next = NIL;
                        free_next   = NIL;
                        mark_next   = '0;
                        fill_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
                if (w2_we_next != '0 || w3_on_next)
                begin
                    state_next = S_WR2;
                end
            end
            S_MOVE:
            begin
                res_next   = rd_b_val;
                found_next = 1'b1;
                state_next = S_DONE;
            end
            S_WR2:
            begin
                wr_idx     = w2_addr_reg;
                wr_en      = w2_we_reg;
                wr_succ    = w2_data_reg;
                wr_pred    = w2_data_reg;
                state_next = w3_on_reg ? S_WR3 : S_DONE;
            end
            S_WR3:
            begin
                wr_idx     = w3_addr_reg;
                wr_en      = '{val: 1'b0, succ: 1'b0, pred: 1'b1};
                wr_pred    = w3_data_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    dlce_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .STORE_W    (STORE_W),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_a_addr (free_reg[ADDR_W-1:0]),
        .rd_b_addr (rd_b_idx[ADDR_W-1:0]),
        .rd_a_succ (rd_a_succ),
        .rd_b_succ (rd_b_succ),
        .rd_b_pred (rd_b_pred),
        .rd_b_val  (rd_b_val),
        .wr_en     (wr_en),
        .wr_addr   (wr_idx[ADDR_W-1:0]),
        .wr_val    (wr_val),
        .wr_succ   (wr_succ),
        .wr_pred   (wr_pred)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cursor_reg    <= NIL;
            free_reg      <= NIL;
            mark_reg      <= '0;
            fill_reg      <= '0;
            w2_we_reg     <= '0;
            w3_on_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            free_reg   <= free_next;
            mark_reg   <= mark_next;
            fill_reg   <= fill_next;
            w2_we_reg  <= w2_we_next;
            w3_on_reg  <= w3_on_next;
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        value_reg   <= value_next;
        anchor_reg  <= anchor_next;
        res_reg     <= res_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        w2_addr_reg <= w2_addr_next;
        w2_data_reg <= w2_data_next;
        w3_addr_reg <= w3_addr_next;
        w3_data_reg <= w3_data_next;
        if (state_reg == S_DONE && slot_free)
        begin
            out_value_reg  <= DATA_W'(res_reg);
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(fill_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_value  = out_value_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.element_count = out_count_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NIL)
        else $error("element count above pool size");

    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((head_reg == NIL) == (tail_reg == NIL)))
        else $error("head and tail disagree on empty list");

    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && head_reg == NIL) |-> (cursor_reg == NIL && fill_reg == '0))
        else $error("empty list with cursor or nonzero count");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.status == ST_OK))
        else $error("returned element with error status");

    a_wr3_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR3) |-> ($past(state_reg) == S_WR2))
        else $error("third link write out of sequence");
`endif

endmodule
